/* sv/cqs_pkg.sv */
// ----------------------------------------------------------------------------
// cqs_pkg
// Shared types, constants and helpers of the circular queue with search.
// ----------------------------------------------------------------------------
package cqs_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CAP_W  = IDX_W + 1;
  localparam int POS_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(DEPTH);

  // register index taken from the word address
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_SRCH = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SRCH,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         pos;
  } res_t;

  // Advance a ring index, wrapping at the effective capacity.
  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx,
                                                input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = CAP_W'(idx) + CAP_W'(1);
    if (n >= cap) n = '0;
    return n[IDX_W-1:0];
  endfunction

endpackage

/* sv/cqs_if.sv */
// ----------------------------------------------------------------------------
// cqs_if
// Valid/ready channels for request and result beats of the queue.
// ----------------------------------------------------------------------------
interface cqs_req_if;
  import cqs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface cqs_rsp_if;
  import cqs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data_out;
  logic [POS_W-1:0]         position;

  modport source (output valid, status, data_out, position, input ready);
  modport sink   (input valid, status, data_out, position, output ready);
endinterface

/* sv/cqs_ram.sv */
// ----------------------------------------------------------------------------
// cqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/cqs_ctrl.sv */
// ----------------------------------------------------------------------------
// cqs_ctrl
// Request sequencer: ring pointers, entry RAM access, search walk and the
// result register.
// ----------------------------------------------------------------------------
module cqs_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cqs_pkg::CAP_W-1:0]     eff_cap_i,
  cqs_req_if.sink                       req,
  cqs_rsp_if.source                     rsp,
  output cqs_pkg::ram_req_t             ram_o,
  input  logic [cqs_pkg::DATA_W-1:0]    ram_rdata_i
);
  import cqs_pkg::*;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [IDX_W-1:0]     tail_q, tail_d;
  logic                 empty_q, empty_d;
  logic [IDX_W-1:0]     cur_q, cur_d;
  logic [POS_W-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0]    key_q, key_d;
  res_t                 res_q, res_d;
  res_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 emit;
  res_t                 emit_res;
  logic                 out_free;
  logic [IDX_W-1:0]     tail_nxt;
  logic [IDX_W-1:0]     cur_nxt;

  assign out_free = !out_valid_q || rsp.ready;
  assign tail_nxt = step_idx(tail_q, eff_cap_i);
  assign cur_nxt  = step_idx(cur_q, eff_cap_i);
  assign req.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    empty_d     = empty_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp.ready;
    emit        = 1'b0;
    emit_res    = '{status: ST_OK, data: '0, pos: '0};
    ram_o       = '{we: 1'b0, waddr: '0, wdata: req.value, raddr: head_q};

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          unique case (mode_e'(req.mode))
            MODE_ENQ: begin
              emit = 1'b1;
              if (!empty_q && tail_nxt == head_q) begin
                emit_res.status = ST_FULL;
              end else begin
                ram_o.we = 1'b1;
                if (empty_q) begin
                  head_d      = '0;
                  tail_d      = '0;
                  empty_d     = 1'b0;
                  ram_o.waddr = '0;
                end else begin
                  tail_d      = tail_nxt;
                  ram_o.waddr = tail_nxt;
                end
              end
            end
            MODE_DEQ: begin
              if (empty_q) begin
                emit            = 1'b1;
                emit_res.status = ST_EMPTY;
              end else begin
                // head entry is being read this cycle; pointers move now
                if (head_q == tail_q) begin
                  head_d  = '0;
                  tail_d  = '0;
                  empty_d = 1'b1;
                end else begin
                  head_d = step_idx(head_q, eff_cap_i);
                end
                state_d = S_DEQ;
              end
            end
            MODE_SRCH: begin
              if (empty_q) begin
                emit            = 1'b1;
                emit_res.status = ST_EMPTY;
              end else begin
                key_d   = req.value;
                cur_d   = head_q;
                cnt_d   = POS_W'(1);
                state_d = S_SRCH;
              end
            end
            MODE_NOP: begin
              emit = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        emit          = 1'b1;
        emit_res.data = ram_rdata_i;
      end
      S_SRCH: begin
        priority if (ram_rdata_i == key_q) begin
          emit         = 1'b1;
          emit_res.pos = cnt_q;
        end else if (cur_q == tail_q || cnt_q == POS_LAST) begin
          emit            = 1'b1;
          emit_res.status = ST_NOTFOUND;
        end else begin
          // fetch the next entry toward the tail
          cur_d       = cur_nxt;
          cnt_d       = cnt_q + POS_W'(1);
          ram_o.raddr = cur_nxt;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // land a finished result in the output register, or park it
    if (emit) begin
      if (out_free) begin
        out_d       = emit_res;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        res_d   = emit_res;
        state_d = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    cnt_q <= cnt_d;
    key_q <= key_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign rsp.valid    = out_valid_q;
  assign rsp.status   = out_q.status;
  assign rsp.data_out = out_q.data;
  assign rsp.position = out_q.pos;

  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HOLD |-> out_valid_q)
    else $error("result parked while output register is free");

  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_o.we |-> (state_q == S_IDLE && req.valid))
    else $error("entry write outside an accepted enqueue");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> (cnt_q != '0 && cnt_q <= POS_LAST))
    else $error("search position out of range");

  a_empty_pointers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0 && tail_q == '0))
    else $error("empty queue with pointers away from zero");

  a_deq_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEQ |=> (state_q == S_IDLE || state_q == S_HOLD))
    else $error("dequeue did not finish in one cycle");

endmodule

/* sv/circular_queue_with_search.sv */
// ----------------------------------------------------------------------------
// circular_queue_with_search
// Ring-buffer queue of signed 32-bit words with enqueue, dequeue and search.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and gives exactly one result beat.
// Enqueue, a refused enqueue, any request on an empty queue and the idle code
// finish in the accept cycle; a dequeue reads the head entry on accept and
// answers from S_DEQ; a search examines n entries (1 to 16) from the head,
// reading one entry per cycle in S_SRCH through the single read port of
// the entry RAM. The request side closes during the read cycles of a dequeue
// or a search, and while a second result is parked behind one that waits in
// the output register; a single waiting result does not close it.
// The capacity register (offset 0x0) limits the ring to 1..16 entries and
// must be written by the user only while the queue is idle (not enforced).
module circular_queue_with_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cqs_pkg::APB_AW-1:0]  paddr,
  input  logic [cqs_pkg::APB_DW-1:0]  pwdata,
  output logic [cqs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  cqs_req_if.sink                     req_i,
  cqs_rsp_if.source                   rsp_o
);
  import cqs_pkg::*;

  logic [CAP_W-1:0]  cap_q;
  logic [CAP_W-1:0]  eff_cap;
  logic              reg_sel;
  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel == REG_CAPACITY) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (reg_sel == REG_CAPACITY) ? APB_DW'(cap_q) : '0;

  // zero acts as one entry, anything above the built depth as the full ring
  always_comb begin
    priority if (cap_q == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_q > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end else begin
      eff_cap = cap_q;
    end
  end

  cqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_cap_i   (eff_cap),
    .req         (req_i),
    .rsp         (rsp_o),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  cqs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* tb/sv/tb_cqs_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cqs_checker
// Watches the request, result and register channels of the circular queue,
// keeps its own copy of the ring and the capacity, predicts the answer to
// every accepted request and compares each result beat with the oldest one.
// ----------------------------------------------------------------------------
module tb_cqs_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [cqs_pkg::APB_AW-1:0] paddr_i,
  input  logic [cqs_pkg::APB_DW-1:0] pwdata_i,
  cqs_req_if                         req_mon_i,
  cqs_rsp_if                         rsp_mon_i,
  output int                         fail_count_o,
  output int                         outstanding_o
);
  import cqs_pkg::*;

  logic signed [DATA_W-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]         head_q;
  logic [IDX_W-1:0]         tail_q;
  logic                     empty_q;
  logic [CAP_W-1:0]         cap_q;
  res_t                     answers_due [$];
  int                       fails;

  // Zero acts as one, anything above the built depth as the depth.
  function automatic int ring_size();
    int sz;
    sz = int'(cap_q);
    if (sz == 0) sz = 1;
    if (sz > DEPTH) sz = DEPTH;
    return sz;
  endfunction

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    int nxt;
    nxt = int'(idx) + 1;
    if (nxt >= ring_size()) nxt = 0;
    return IDX_W'(nxt);
  endfunction

  function automatic res_t apply_queue_request(input logic [MODE_W-1:0] mode,
                                               input logic signed [DATA_W-1:0] value);
    res_t             res;
    logic [IDX_W-1:0] cur;
    res.status = ST_OK;
    res.data   = '0;
    res.pos    = '0;
    case (mode_e'(mode))
      MODE_ENQ: begin
        if (!empty_q && ring_next(tail_q) == head_q) begin
          res.status = ST_FULL;
        end else begin
          if (empty_q) begin
            head_q  = '0;
            tail_q  = '0;
            empty_q = 1'b0;
          end else begin
            tail_q = ring_next(tail_q);
          end
          ring_words[tail_q] = value;
        end
      end
      MODE_DEQ: begin
        if (empty_q) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = ring_words[head_q];
          // last entry out: both indices return to zero
          if (head_q == tail_q) begin
            head_q  = '0;
            tail_q  = '0;
            empty_q = 1'b1;
          end else begin
            head_q = ring_next(head_q);
          end
        end
      end
      MODE_SRCH: begin
        if (empty_q) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          cur = head_q;
          // the walk gives up after DEPTH entries even if it never meets the tail
          for (int k = 1; k <= DEPTH; k++) begin
            if (ring_words[cur] == value) begin
              res.status = ST_OK;
              res.pos    = POS_W'(k);
              break;
            end
            if (cur == tail_q) break;
            cur = ring_next(cur);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) ring_words[i] = '0;
      head_q  = '0;
      tail_q  = '0;
      empty_q = 1'b1;
      cap_q   = CAP_RESET;
      fails   = 0;
      answers_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[APB_AW-1:2] == REG_CAPACITY) begin
        cap_q = pwdata_i[CAP_W-1:0];
      end
      // take the request first so a same-edge answer finds its expectation
      if (req_mon_i.valid && req_mon_i.ready) begin
        answers_due.push_back(apply_queue_request(req_mon_i.mode, req_mon_i.value));
      end
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (answers_due.size() == 0) begin
          $error("result beat with no request waiting: status %0d data %0d position %0d",
                 rsp_mon_i.status, rsp_mon_i.data_out, rsp_mon_i.position);
          fails++;
        end else begin
          want = answers_due.pop_front();
          if (rsp_mon_i.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp_mon_i.status);
            fails++;
          end
          if (rsp_mon_i.data_out !== want.data) begin
            $error("data_out mismatch: expected %0d, got %0d", want.data,
                   rsp_mon_i.data_out);
            fails++;
          end
          if (rsp_mon_i.position !== want.pos) begin
            $error("position mismatch: expected %0d, got %0d", want.pos,
                   rsp_mon_i.position);
            fails++;
          end
        end
      end
    end
    fail_count_o  <= fails;
    outstanding_o <= answers_due.size();
  end

endmodule

/* tb/sv/tb_circular_queue_with_search.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_queue_with_search
// Stimulus and verdict for the circular queue with search. Directed requests
// hit the empty, full, first-match and no-op cases; a fill and partial drain
// writes every ring entry; then phases of random enqueue, dequeue and search
// traffic run under a sweep of capacities, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_circular_queue_with_search;
  import cqs_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int                fail_count;
  int                outstanding;

  logic              src_idle;
  logic              sink_idle;
  int                long_holds_asked;
  int                long_holds_done;
  logic [DATA_W-1:0] recent_words [$];

  cqs_req_if req_ch ();
  cqs_rsp_if rsp_ch ();

  circular_queue_with_search dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch)
  );

  tb_cqs_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .req_mon_i     (req_ch),
    .rsp_mon_i     (rsp_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #3_000_000;
    $display("circular_queue_with_search verification failed");
    $finish;
  end

  // Result side: random stalls per beat, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    rsp_ch.ready    = 1'b0;
    long_holds_done = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_holds_asked > long_holds_done) begin
        stall = 150;
        long_holds_done++;
      end else if (sink_idle) begin
        stall = $urandom_range(0, 8);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_ch.valid !== 1'b1);
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return DATA_W'($urandom_range(0, 3));
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Leave valid high after the beat; drop_request lowers it, the next call only for a gap.
  task automatic send_request(input mode_e mode, input logic [DATA_W-1:0] value);
    int gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.value <= value;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    if (mode == MODE_ENQ) begin
      recent_words.push_back(value);
      if (recent_words.size() > DEPTH) void'(recent_words.pop_front());
    end
  endtask

  task automatic drop_request();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
  endtask

  // Hold the sender until every answer is back, then pause.
  task automatic drain_results();
    drop_request();
    wait (outstanding == 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    logic [APB_DW-1:0] wdata;
    wdata = ($urandom_range(0, 1) == 1) ? APB_DW'($urandom()) : '0;
    wdata[CAP_W-1:0] = cap;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({REG_CAPACITY, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mix of operations by percentage; searches mostly look for recently enqueued words.
  task automatic run_ops(input int count, input int enq_pct, input int deq_pct);
    int                roll;
    mode_e             mode;
    logic [DATA_W-1:0] value;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) mode = MODE_NOP;
      else if (roll < 4 + enq_pct) mode = MODE_ENQ;
      else if (roll < 4 + enq_pct + deq_pct) mode = MODE_DEQ;
      else mode = MODE_SRCH;
      value = pick_word();
      if (mode == MODE_SRCH && recent_words.size() > 0 && $urandom_range(0, 9) < 7) begin
        value = recent_words[$urandom_range(0, recent_words.size() - 1)];
      end
      send_request(mode, value);
    end
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] last_word;
    logic [CAP_W-1:0]  cap;
    int                cap_plan [10];

    cap_plan         = '{1, 0, 31, 17, 2, 3, 16, 8, 5, 15};
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.mode      = MODE_NOP;
    req_ch.value     = '0;
    src_idle         = 1'b1;
    sink_idle        = 1'b1;
    long_holds_asked = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // empty queue, idle code, then extremes at the reset capacity
    send_request(MODE_DEQ, 32'h1234_5678);
    send_request(MODE_SRCH, 32'h0000_0000);
    send_request(MODE_NOP, 32'hFFFF_FFFF);
    send_request(MODE_ENQ, 32'h8000_0000);
    send_request(MODE_ENQ, 32'h7FFF_FFFF);
    send_request(MODE_ENQ, 32'h0000_0000);
    send_request(MODE_ENQ, 32'hFFFF_FFFF);
    send_request(MODE_ENQ, 32'h5555_5555);
    send_request(MODE_ENQ, 32'hAAAA_AAAA);
    send_request(MODE_SRCH, 32'h8000_0000);
    send_request(MODE_SRCH, 32'hAAAA_AAAA);
    send_request(MODE_SRCH, 32'h1234_5678);
    // duplicate: the search must report the first match from the head
    send_request(MODE_ENQ, 32'h7FFF_FFFF);
    send_request(MODE_SRCH, 32'h7FFF_FFFF);
    send_request(MODE_NOP, 32'h5A5A_5A5A);
    send_request(MODE_DEQ, 32'h0000_0000);
    send_request(MODE_DEQ, 32'hFFFF_FFFF);

    // fill to the full depth so every ring entry holds a written word
    repeat (11) send_request(MODE_ENQ, pick_word());
    last_word = recent_words[$];
    send_request(MODE_ENQ, pick_word());
    send_request(MODE_SRCH, last_word);
    repeat (10) send_request(MODE_DEQ, pick_word());

    for (int ph = 0; ph < 16; ph++) begin
      drain_results();
      if (ph < 10) begin
        cap = CAP_W'(cap_plan[ph]);
      end else begin
        cap = ($urandom_range(0, 3) == 0) ? CAP_W'($urandom_range(17, 31))
                                          : CAP_W'($urandom_range(0, 16));
      end
      write_capacity(cap);
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      if (ph == 4) begin
        // back up the result side while requests keep coming
        src_idle = 1'b0;
        long_holds_asked++;
      end
      case (ph % 3)
        0:       run_ops(45, 55, 20);
        1:       run_ops(45, 20, 55);
        default: run_ops(45, 38, 30);
      endcase
    end

    drain_results();
    if (fail_count == 0 && outstanding == 0) begin
      $display("circular_queue_with_search verification clean");
    end else begin
      $display("circular_queue_with_search verification failed");
    end
    $finish;
  end

endmodule
